/* design/spp_pkg.sv */
`default_nettype none

package spp_pkg;

    // Fractional bits of the fixed-point format
    localparam int FRAC_BITS = 16;

    // Operations of the shared iterative unit
    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } op_t;

    // Steps of one item, walked by the controller
    typedef enum logic [4:0] {
        STP_DIST_X,
        STP_DIST_Y,
        STP_DIST_RT,
        STP_SPD_X,
        STP_SPD_Y,
        STP_SPD_RT,
        STP_TEST,
        STP_PRED,
        STP_MOVE_X,
        STP_MOVE_Y,
        STP_MAG_X,
        STP_MAG_Y,
        STP_MAG_RT,
        STP_ACC_XM,
        STP_ACC_XD,
        STP_ACC_YM,
        STP_ACC_YD
    } step_t;

    // Controller to datapath
    typedef struct packed {
        logic  load;
        logic  start;
        logic  capture;
        logic  out_load;
        step_t step;
    } ctrl_t;

    // Datapath to controller
    typedef struct packed {
        logic pursue;
        logic fast;
        logic mag_zero;
        logic iter_done;
        logic out_free;
    } stat_t;

    // Magnitude of a 34-bit two's complement value
    function automatic logic [33:0] abs34(input logic [33:0] v);
        logic [33:0] r;
        r = v[33] ? (~v + 34'd1) : v;
        return r;
    endfunction

    // Clamp a 65-bit signed sum to the signed 32-bit range
    function automatic logic [31:0] sat32(input logic [64:0] v);
        logic [31:0] r;
        if (!v[64] && (v[63:31] != 33'd0))
            r = 32'h7FFF_FFFF;
        else if (v[64] && (v[63:31] != {33{1'b1}}))
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

/* design/spp_iter.sv */
`default_nettype none

// Shared bit-serial unit: 34x34 multiply, 64/34 divide, 68-bit square root
module spp_iter (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire spp_pkg::op_t     op,
    input  wire logic [67:0]      opa,
    input  wire logic [33:0]      opb,
    output logic                  done,
    output logic [67:0]           res
);

    spp_pkg::op_t op_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [6:0]   cnt_reg;
    logic [67:0]  acc_reg;
    logic [36:0]  rem_reg;
    logic [33:0]  root_reg;
    logic [33:0]  mcand_reg;

    logic [67:0]  acc_next;
    logic [36:0]  rem_next;
    logic [33:0]  root_next;

    logic [34:0]  mul_up;
    logic [34:0]  div_sh;
    logic [35:0]  div_diff;
    logic [36:0]  sq_sh;
    logic [36:0]  sq_trial;

    // One iteration of the selected operation
    always_comb
    begin
        mul_up    = acc_reg[0] ? ({1'b0, acc_reg[67:34]} + {1'b0, mcand_reg})
                               : {1'b0, acc_reg[67:34]};
        div_sh    = {rem_reg[33:0], acc_reg[63]};
        div_diff  = {1'b0, div_sh} - {2'b00, mcand_reg};
        sq_sh     = {rem_reg[34:0], acc_reg[67:66]};
        sq_trial  = {1'b0, root_reg, 2'b01};
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        case (op_reg)
            spp_pkg::OP_MUL:
            begin
                acc_next = {mul_up, acc_reg[33:1]};
            end
            spp_pkg::OP_DIV:
            begin
                if (!div_diff[35])
                begin
                    rem_next = {2'b00, div_diff[34:0]};
                    acc_next = {4'b0000, acc_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = {2'b00, div_sh};
                    acc_next = {4'b0000, acc_reg[62:0], 1'b0};
                end
            end
            spp_pkg::OP_SQRT:
            begin
                acc_next = {acc_reg[65:0], 2'b00};
                if (sq_sh >= sq_trial)
                begin
                    rem_next  = sq_sh - sq_trial;
                    root_next = {root_reg[32:0], 1'b1};
                end
                else
                begin
                    rem_next  = sq_sh;
                    root_next = {root_reg[32:0], 1'b0};
                end
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    // Control: iteration count and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
            op_reg   <= spp_pkg::OP_MUL;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                op_reg   <= op;
                cnt_reg  <= (op == spp_pkg::OP_DIV) ? 7'd64 : 7'd34;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= 37'd0;
            root_reg <= 34'd0;
            case (op)
                spp_pkg::OP_MUL:
                begin
                    acc_reg   <= {34'd0, opb};
                    mcand_reg <= opa[33:0];
                end
                spp_pkg::OP_DIV:
                begin
                    acc_reg   <= {4'b0000, opa[63:0]};
                    mcand_reg <= opb;
                end
                default:
                begin
                    acc_reg   <= opa;
                    mcand_reg <= opb;
                end
            endcase
        end
        else if (busy_reg)
        begin
            acc_reg  <= acc_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign done = done_reg;

    always_comb
    begin
        case (op_reg)
            spp_pkg::OP_MUL:  res = acc_reg;
            spp_pkg::OP_DIV:  res = {4'b0000, acc_reg[63:0]};
            spp_pkg::OP_SQRT: res = {34'd0, root_reg};
            default:          res = acc_reg;
        endcase
    end

endmodule

`default_nettype wire

/* design/spp_dpath.sv */
`default_nettype none

module spp_dpath (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire spp_pkg::ctrl_t  ctrl,
    output spp_pkg::stat_t       stat,
    input  wire logic            cfg_we,
    input  wire logic            cfg_index,
    input  wire logic [30:0]     cfg_data,
    input  wire logic [255:0]    in_data,
    input  wire logic [2:0]      in_user,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [63:0]          out_data,
    output logic                 out_user
);

    localparam logic CFG_MAX_ACCEL = 1'b0;
    localparam logic CFG_MAX_PRED  = 1'b1;

    logic [30:0] max_accel_reg;
    logic [30:0] max_pred_reg;
    logic [31:0] self_x_reg;
    logic [31:0] self_y_reg;
    logic [31:0] targ_x_reg;
    logic [31:0] targ_y_reg;
    logic        pursue_reg;
    logic [31:0] svx_reg;
    logic [31:0] svy_reg;
    logic [31:0] tvx_reg;
    logic [31:0] tvy_reg;
    logic [67:0] sq_reg;
    logic [33:0] dist_reg;
    logic [33:0] speed_reg;
    logic [33:0] mag_reg;
    logic [30:0] pred_reg;
    logic        fast_reg;
    logic        zero_reg;
    logic [63:0] prod_reg;
    logic [31:0] ax_reg;
    logic [31:0] ay_reg;
    logic        ovalid_reg;
    logic [63:0] odata_reg;
    logic        ouser_reg;

    logic [32:0]  dx;
    logic [32:0]  dy;
    logic [33:0]  abs_dx;
    logic [33:0]  abs_dy;
    spp_pkg::op_t op;
    logic [67:0]  opa;
    logic [33:0]  opb;
    logic         iter_done;
    logic [67:0]  res;
    logic [63:0]  off;
    logic [64:0]  mv_pos;
    logic [64:0]  mv_sum;
    logic         mv_neg;
    logic [31:0]  q_signed;
    logic         q_neg;

    // Difference of stored positions
    assign dx     = {targ_x_reg[31], targ_x_reg} - {self_x_reg[31], self_x_reg};
    assign dy     = {targ_y_reg[31], targ_y_reg} - {self_y_reg[31], self_y_reg};
    assign abs_dx = spp_pkg::abs34({dx[32], dx});
    assign abs_dy = spp_pkg::abs34({dy[32], dy});

    // Operand selection per step
    always_comb
    begin
        op  = spp_pkg::OP_MUL;
        opa = 68'd0;
        opb = 34'd0;
        case (ctrl.step)
            spp_pkg::STP_DIST_X, spp_pkg::STP_MAG_X:
            begin
                opa = {34'd0, abs_dx};
                opb = abs_dx;
            end
            spp_pkg::STP_DIST_Y, spp_pkg::STP_MAG_Y:
            begin
                opa = {34'd0, abs_dy};
                opb = abs_dy;
            end
            spp_pkg::STP_SPD_X:
            begin
                opa = {34'd0, spp_pkg::abs34({{2{svx_reg[31]}}, svx_reg})};
                opb = spp_pkg::abs34({{2{svx_reg[31]}}, svx_reg});
            end
            spp_pkg::STP_SPD_Y:
            begin
                opa = {34'd0, spp_pkg::abs34({{2{svy_reg[31]}}, svy_reg})};
                opb = spp_pkg::abs34({{2{svy_reg[31]}}, svy_reg});
            end
            spp_pkg::STP_DIST_RT, spp_pkg::STP_SPD_RT, spp_pkg::STP_MAG_RT:
            begin
                op  = spp_pkg::OP_SQRT;
                opa = sq_reg;
            end
            spp_pkg::STP_TEST:
            begin
                opa = {34'd0, speed_reg};
                opb = {3'b000, max_pred_reg};
            end
            spp_pkg::STP_PRED:
            begin
                op  = spp_pkg::OP_DIV;
                opa = {4'b0000, 64'(dist_reg) << spp_pkg::FRAC_BITS};
                opb = speed_reg;
            end
            spp_pkg::STP_MOVE_X:
            begin
                opa = {34'd0, spp_pkg::abs34({{2{tvx_reg[31]}}, tvx_reg})};
                opb = {3'b000, pred_reg};
            end
            spp_pkg::STP_MOVE_Y:
            begin
                opa = {34'd0, spp_pkg::abs34({{2{tvy_reg[31]}}, tvy_reg})};
                opb = {3'b000, pred_reg};
            end
            spp_pkg::STP_ACC_XM:
            begin
                opa = {34'd0, abs_dx};
                opb = {3'b000, max_accel_reg};
            end
            spp_pkg::STP_ACC_YM:
            begin
                opa = {34'd0, abs_dy};
                opb = {3'b000, max_accel_reg};
            end
            spp_pkg::STP_ACC_XD, spp_pkg::STP_ACC_YD:
            begin
                op  = spp_pkg::OP_DIV;
                opa = {4'b0000, prod_reg};
                opb = mag_reg;
            end
            default:
            begin
                op = spp_pkg::OP_MUL;
            end
        endcase
    end

    spp_iter u_iter (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctrl.start),
        .op    (op),
        .opa   (opa),
        .opb   (opb),
        .done  (iter_done),
        .res   (res)
    );

    // Target moved along its velocity, saturated
    assign off    = res[63:0] >> spp_pkg::FRAC_BITS;
    assign mv_neg = (ctrl.step == spp_pkg::STP_MOVE_X) ? tvx_reg[31] : tvy_reg[31];
    assign mv_pos = (ctrl.step == spp_pkg::STP_MOVE_X) ? {{33{targ_x_reg[31]}}, targ_x_reg}
                                                       : {{33{targ_y_reg[31]}}, targ_y_reg};
    assign mv_sum = mv_neg ? (mv_pos - {1'b0, off}) : (mv_pos + {1'b0, off});

    // Signed accel component from the quotient
    assign q_neg    = (ctrl.step == spp_pkg::STP_ACC_XD) ? dx[32] : dy[32];
    assign q_signed = q_neg ? (32'd0 - {1'b0, res[30:0]}) : {1'b0, res[30:0]};

    // Configuration and stored positions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_accel_reg <= 31'd65536;
            max_pred_reg  <= 31'd65536;
            self_x_reg    <= 32'd0;
            self_y_reg    <= 32'd0;
            targ_x_reg    <= 32'd0;
            targ_y_reg    <= 32'd0;
        end
        else
        begin
            if (cfg_we && (cfg_index == CFG_MAX_ACCEL))
                max_accel_reg <= cfg_data;
            if (cfg_we && (cfg_index == CFG_MAX_PRED))
                max_pred_reg <= cfg_data;
            if (ctrl.load && in_user[1])
            begin
                self_x_reg <= in_data[31:0];
                self_y_reg <= in_data[63:32];
            end
            if (ctrl.load && in_user[2])
            begin
                targ_x_reg <= in_data[95:64];
                targ_y_reg <= in_data[127:96];
            end
            if (ctrl.capture && (ctrl.step == spp_pkg::STP_MOVE_X))
                targ_x_reg <= spp_pkg::sat32(mv_sum);
            if (ctrl.capture && (ctrl.step == spp_pkg::STP_MOVE_Y))
                targ_y_reg <= spp_pkg::sat32(mv_sum);
        end
    end

    // Item registers and intermediate results
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            pursue_reg <= in_user[0];
            svx_reg    <= in_data[159:128];
            svy_reg    <= in_data[191:160];
            tvx_reg    <= in_data[223:192];
            tvy_reg    <= in_data[255:224];
        end
        if (ctrl.capture)
        begin
            case (ctrl.step)
                spp_pkg::STP_DIST_X, spp_pkg::STP_SPD_X, spp_pkg::STP_MAG_X:
                    sq_reg <= res;
                spp_pkg::STP_DIST_Y, spp_pkg::STP_SPD_Y, spp_pkg::STP_MAG_Y:
                    sq_reg <= sq_reg + res;
                spp_pkg::STP_DIST_RT:
                    dist_reg <= res[33:0];
                spp_pkg::STP_SPD_RT:
                    speed_reg <= res[33:0];
                spp_pkg::STP_TEST:
                begin
                    fast_reg <= (res <= (68'(dist_reg) << spp_pkg::FRAC_BITS));
                    pred_reg <= max_pred_reg;
                end
                spp_pkg::STP_PRED:
                    pred_reg <= res[30:0];
                spp_pkg::STP_MAG_RT:
                begin
                    mag_reg  <= res[33:0];
                    zero_reg <= (res[33:0] == 34'd0);
                    ax_reg   <= 32'd0;
                    ay_reg   <= 32'd0;
                end
                spp_pkg::STP_ACC_XM, spp_pkg::STP_ACC_YM:
                    prod_reg <= res[63:0];
                spp_pkg::STP_ACC_XD:
                    ax_reg <= q_signed;
                spp_pkg::STP_ACC_YD:
                    ay_reg <= q_signed;
                default:
                    sq_reg <= sq_reg;
            endcase
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (ctrl.out_load)
            ovalid_reg <= 1'b1;
        else if (out_ready)
            ovalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            odata_reg <= {ay_reg, ax_reg};
            ouser_reg <= zero_reg;
        end
    end

    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;
    assign out_user  = ouser_reg;

    assign stat.pursue    = pursue_reg;
    assign stat.fast      = fast_reg;
    assign stat.mag_zero  = zero_reg;
    assign stat.iter_done = iter_done;
    assign stat.out_free  = !ovalid_reg || out_ready;

endmodule

`default_nettype wire

/* design/spp_ctrl.sv */
`default_nettype none

module spp_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire spp_pkg::stat_t  stat,
    output spp_pkg::ctrl_t       ctrl
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIRST,
        ST_ISSUE,
        ST_WAIT,
        ST_ADV,
        ST_OUT
    } state_t;

    state_t         state_reg;
    spp_pkg::step_t step_reg;
    spp_pkg::step_t step_next;
    logic           last;

    // Step sequencing
    always_comb
    begin
        last      = 1'b0;
        step_next = step_reg;
        case (step_reg)
            spp_pkg::STP_DIST_X:  step_next = spp_pkg::STP_DIST_Y;
            spp_pkg::STP_DIST_Y:  step_next = spp_pkg::STP_DIST_RT;
            spp_pkg::STP_DIST_RT: step_next = spp_pkg::STP_SPD_X;
            spp_pkg::STP_SPD_X:   step_next = spp_pkg::STP_SPD_Y;
            spp_pkg::STP_SPD_Y:   step_next = spp_pkg::STP_SPD_RT;
            spp_pkg::STP_SPD_RT:  step_next = spp_pkg::STP_TEST;
            spp_pkg::STP_TEST:
                step_next = stat.fast ? spp_pkg::STP_MOVE_X : spp_pkg::STP_PRED;
            spp_pkg::STP_PRED:    step_next = spp_pkg::STP_MOVE_X;
            spp_pkg::STP_MOVE_X:  step_next = spp_pkg::STP_MOVE_Y;
            spp_pkg::STP_MOVE_Y:  step_next = spp_pkg::STP_MAG_X;
            spp_pkg::STP_MAG_X:   step_next = spp_pkg::STP_MAG_Y;
            spp_pkg::STP_MAG_Y:   step_next = spp_pkg::STP_MAG_RT;
            spp_pkg::STP_MAG_RT:
            begin
                step_next = spp_pkg::STP_ACC_XM;
                last      = stat.mag_zero;
            end
            spp_pkg::STP_ACC_XM:  step_next = spp_pkg::STP_ACC_XD;
            spp_pkg::STP_ACC_XD:  step_next = spp_pkg::STP_ACC_YM;
            spp_pkg::STP_ACC_YM:  step_next = spp_pkg::STP_ACC_YD;
            spp_pkg::STP_ACC_YD:  last = 1'b1;
            default:              last = 1'b1;
        endcase
    end

    // State and step register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= spp_pkg::STP_MAG_X;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                    if (in_valid)
                        state_reg <= ST_FIRST;
                ST_FIRST:
                begin
                    step_reg  <= stat.pursue ? spp_pkg::STP_DIST_X : spp_pkg::STP_MAG_X;
                    state_reg <= ST_ISSUE;
                end
                ST_ISSUE:
                    state_reg <= ST_WAIT;
                ST_WAIT:
                    if (stat.iter_done)
                        state_reg <= ST_ADV;
                ST_ADV:
                begin
                    if (last)
                        state_reg <= ST_OUT;
                    else
                    begin
                        step_reg  <= step_next;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_OUT:
                    if (stat.out_free)
                        state_reg <= ST_IDLE;
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign in_ready      = (state_reg == ST_IDLE);
    assign ctrl.load     = in_valid && (state_reg == ST_IDLE);
    assign ctrl.start    = (state_reg == ST_ISSUE);
    assign ctrl.capture  = (state_reg == ST_WAIT) && stat.iter_done;
    assign ctrl.out_load = (state_reg == ST_OUT) && stat.out_free;
    assign ctrl.step     = step_reg;

endmodule

`default_nettype wire

/* design/seek_pursue_steering_top.sv */
`default_nettype none

// Channel   Dir  tdata                                     tuser
// s_axis    in   self_x, self_y, target_x, target_y,        command, self_present,
//                self_vel_x/y, target_vel_x/y (32b each)    target_present
// m_axis    out  accel_x, accel_y (32b each)               zero_direction
// cfg       in   index 0 max_acceleration, 1 max_prediction (31b, no read-back)
//
// One item at a time through a bit-serial multiply/divide/sqrt unit; each step
// runs 34 iterations, or 64 for a divide. Seek: magnitude steps, then the
// acceleration steps unless the positions coincide. Pursue first runs the distance,
// speed, test and move steps, with the prediction divide only when it is needed.
// Reset clears the stored positions and loads 1.0 into both registers.
// Input is taken again once the previous result sits in the output register.
module seek_pursue_steering_top (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // self_x, self_y, target_x, target_y, self_vel_x, self_vel_y,
    // target_vel_x, target_vel_y
    input  wire logic [255:0] s_axis_tdata,
    // command, self_present, target_present
    input  wire logic [2:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // accel_x, accel_y
    output logic [63:0]       m_axis_tdata,
    // zero_direction
    output logic [0:0]        m_axis_tuser,
    input  wire logic         cfg_we,
    input  wire logic         cfg_index,
    input  wire logic [30:0]  cfg_data
);

    spp_pkg::ctrl_t ctrl;
    spp_pkg::stat_t stat;

    spp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    spp_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_axis_tdata),
        .in_user   (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser[0])
    );

endmodule

`default_nettype wire

/* dv/testbench.sv */
`default_nettype none

module testbench;

    localparam int FB = spp_pkg::FRAC_BITS;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // self_x, self_y, target_x, target_y, self_vel_x, self_vel_y,
    // target_vel_x, target_vel_y
    logic [255:0] s_axis_tdata;
    // command, self_present, target_present
    logic [2:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // accel_x, accel_y
    logic [63:0]  m_axis_tdata;
    // zero_direction
    logic [0:0]   m_axis_tuser;
    logic         cfg_we;
    logic         cfg_index;
    logic [30:0]  cfg_data;

    localparam logic CMD_SEEK   = 1'b0;
    localparam logic CMD_PURSUE = 1'b1;
    localparam logic REG_MAX_ACC  = 1'b0;
    localparam logic REG_MAX_PRED = 1'b1;

    typedef struct packed {
        logic [31:0] ax;
        logic [31:0] ay;
        logic        zero_dir;
    } steer_t;

    steer_t steer_q[$];
    int     err_count;
    int     idle_pct;
    int     hold_cycles;

    // predictor copy of the block state
    logic [30:0] max_acc;
    logic [30:0] max_pred;
    logic signed [31:0] own_x, own_y, tgt_x, tgt_y;

    seek_pursue_steering_top u_dut (.*);

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    initial
    begin
        #40000000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        err_count++;
    endtask

    // floor(sqrt(x^2 + y^2)) on 33-bit differences
    function automatic logic [33:0] vec_len(input logic signed [33:0] x,
                                            input logic signed [33:0] y);
        logic [67:0]  sum;
        logic [67:0]  c;
        logic [33:0]  r;
        logic [33:0]  ux, uy;
        ux  = x[33] ? -x : x;
        uy  = y[33] ? -y : y;
        sum = 68'(ux) * 68'(ux) + 68'(uy) * 68'(uy);
        r   = '0;
        for (int b = 33; b >= 0; b--)
        begin
            c = 68'(r | (34'd1 << b));
            if (c * c <= sum)
                r = r | (34'd1 << b);
        end
        return r;
    endfunction

    function automatic logic [31:0] shift_target(input logic signed [31:0] pos,
                                                 input logic signed [31:0] vel,
                                                 input logic [63:0] pred);
        logic [63:0]        mag;
        logic [127:0]       off;
        logic signed [64:0] s;
        mag = vel[31] ? 64'(-65'(vel)) : 64'(vel);
        off = (128'(mag) * 128'(pred)) >> FB;
        s   = 65'(pos) + (vel[31] ? -$signed(65'(off)) : $signed(65'(off)));
        if (s > 65'sd2147483647)
            return 32'h7FFF_FFFF;
        if (s < -65'sd2147483648)
            return 32'h8000_0000;
        return s[31:0];
    endfunction

    function automatic logic [31:0] scale_acc(input logic signed [33:0] d,
                                              input logic [33:0] len);
        logic [33:0] ud;
        logic [95:0] q;
        ud = d[33] ? -d : d;
        q  = (96'(ud) * 96'(max_acc)) / 96'(len);
        return d[33] ? -q[31:0] : q[31:0];
    endfunction

    // expected steering for one item, updating stored positions
    function automatic steer_t steer_predict(input logic [2:0] u, input logic [255:0] d);
        steer_t r;
        logic signed [33:0] dx, dy;
        logic [33:0] span, spd, len;
        logic [63:0] pred;
        if (u[1])
        begin
            own_x = d[31:0];
            own_y = d[63:32];
        end
        if (u[2])
        begin
            tgt_x = d[95:64];
            tgt_y = d[127:96];
        end
        if (u[0] == CMD_PURSUE)
        begin
            span = vec_len(34'(tgt_x) - 34'(own_x), 34'(tgt_y) - 34'(own_y));
            spd  = vec_len(34'($signed(d[159:128])), 34'($signed(d[191:160])));
            if (96'(spd) * 96'(max_pred) <= (96'(span) << FB))
                pred = 64'(max_pred);
            else
                pred = 64'((96'(span) << FB) / 96'(spd));
            tgt_x = shift_target(tgt_x, d[223:192], pred);
            tgt_y = shift_target(tgt_y, d[255:224], pred);
        end
        dx  = 34'(tgt_x) - 34'(own_x);
        dy  = 34'(tgt_y) - 34'(own_y);
        len = vec_len(dx, dy);
        if (len == 0)
            r = '{32'd0, 32'd0, 1'b1};
        else
            r = '{scale_acc(dx, len), scale_acc(dy, len), 1'b0};
        return r;
    endfunction

    // valid stays high after a transfer; wait_drained drops it
    task automatic send_item(input logic [2:0] u, input logic [255:0] d);
        if ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= u;
        s_axis_tdata  <= d;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        steer_q.push_back(steer_predict(u, d));
    endtask

    task automatic wait_drained();
        int n;
        n = 0;
        s_axis_tvalid <= 1'b0;
        while (steer_q.size() != 0)
            @(posedge clk);
        while (n < 800)
        begin
            @(posedge clk);
            n++;
        end
    endtask

    task automatic write_reg(input logic idx, input logic [30:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_MAX_ACC)
            max_acc = val;
        else
            max_pred = val;
        @(posedge clk);
    endtask

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(4))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(2000000)) - 1000000);
        endcase
    endfunction

    function automatic logic [255:0] rnd_data();
        logic [255:0] d;
        for (int i = 0; i < 8; i++)
            d[i*32 +: 32] = rnd_coord();
        return d;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        steer_t w;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (steer_q.size() == 0)
                report("unexpected result", m_axis_tdata[31:0], 32'd0);
            else
            begin
                w = steer_q.pop_front();
                if (m_axis_tdata[31:0] !== w.ax)
                    report("accel_x", m_axis_tdata[31:0], w.ax);
                if (m_axis_tdata[63:32] !== w.ay)
                    report("accel_y", m_axis_tdata[63:32], w.ay);
                if (m_axis_tuser[0] !== w.zero_dir)
                    report("zero_direction", 32'(m_axis_tuser[0]), 32'(w.zero_dir));
            end
        end
    end

    // receiver back-pressure, with a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles   <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end

    task automatic test_directed();
        logic [255:0] z;
        z = '0;
        send_item({1'b0, 1'b0, CMD_SEEK}, z);
        send_item({1'b1, 1'b1, CMD_SEEK}, {160'd0, 32'h0001_0000, 32'h0001_0000, 64'd0});
        send_item({1'b1, 1'b1, CMD_SEEK}, {128'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                          32'h8000_0000, 32'h8000_0000});
        send_item({1'b1, 1'b1, CMD_SEEK}, {128'd0, 32'h8000_0000, 32'h8000_0000,
                                          32'h7FFF_FFFF, 32'h7FFF_FFFF});
        send_item({1'b1, 1'b1, CMD_PURSUE}, {32'h0001_0000, 32'h0002_0000, 64'd0,
                                            32'h0005_0000, 32'h0003_0000, 64'd0});
        send_item({1'b0, 1'b0, CMD_PURSUE}, {32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                            64'hFFFF_FFFF_FFFF_FFFF, 128'd0});
        send_item({1'b0, 1'b0, CMD_PURSUE}, {32'h8000_0000, 32'h8000_0000,
                                            64'h8000_0000_8000_0000, 128'd0});
        send_item({1'b1, 1'b0, CMD_SEEK}, {192'd0, 32'h1234_5678, 32'h9ABC_DEF0});
        send_item({1'b0, 1'b1, CMD_PURSUE}, {~128'd0, 128'd0});
        send_item({1'b1, 1'b1, CMD_PURSUE}, {32'h0000_0100, 32'hFFFF_FF00, 64'd0,
                                            32'h0001_0000, 32'h0001_0000, 64'd0});
        wait_drained();
    endtask

    task automatic test_random(input int count, input int seek_pct);
        logic [2:0] u;
        for (int i = 0; i < count; i++)
        begin
            u[0] = ($urandom_range(99) < seek_pct) ? CMD_SEEK : CMD_PURSUE;
            u[1] = $urandom_range(3) != 0;
            u[2] = $urandom_range(3) != 0;
            send_item(u, rnd_data());
        end
    endtask

    task automatic test_stall();
        hold_cycles = 3000;
        test_random(12, 50);
        wait_drained();
        test_random(6, 50);
        wait_drained();
    endtask

    task automatic test_config();
        write_reg(REG_MAX_ACC, 31'h7FFF_FFFF);
        write_reg(REG_MAX_PRED, 31'h7FFF_FFFF);
        test_random(150, 40);
        wait_drained();
        write_reg(REG_MAX_ACC, 31'd0);
        write_reg(REG_MAX_PRED, 31'd0);
        test_random(100, 40);
        wait_drained();
        write_reg(REG_MAX_ACC, 31'($urandom));
        write_reg(REG_MAX_PRED, 31'd1);
        test_random(150, 40);
        wait_drained();
        write_reg(REG_MAX_ACC, 31'h0001_0000);
        write_reg(REG_MAX_PRED, 31'($urandom_range(32'h0010_0000)));
        test_random(200, 40);
        wait_drained();
    endtask

    initial
    begin
        err_count     = 0;
        idle_pct      = 34;
        hold_cycles   = 0;
        max_acc       = 31'h0001_0000;
        max_pred      = 31'h0001_0000;
        own_x = 0; own_y = 0; tgt_x = 0; tgt_y = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = 1'b0;
        cfg_data      = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_stall();
        test_config();
        // stretch with no idling on either side
        idle_pct = 0;
        test_random(150, 50);
        wait_drained();
        idle_pct = 34;
        test_random(150, 50);
        wait_drained();
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
